// ===== hdl/pfd_pkg.sv =====
package pfd_pkg;

	localparam int DATA_WIDTH_DEF = 32;

	localparam int WORD_W  = 32;
	localparam int CFG_W   = 31;
	localparam int STATE_W = 32;
	localparam int DIFF_W  = 33;
	localparam int FRAC_W  = 16;
	localparam int MAG_W   = 47;
	localparam int OPND_W  = 48;
	localparam int SUM_W   = 49;
	localparam int CHUNK_W = 24;
	localparam int DVD_W   = DIFF_W + FRAC_W;
	localparam int IDX_W   = 3;

	localparam logic [MAG_W-1:0] SAT_Q = {1'b1, {(MAG_W-1){1'b0}}};
	localparam int CLAMP_Q = 6553600;
	localparam int SQRT2_Q = 92682;

	localparam logic [CFG_W-1:0] CUTOFF_RESET = 31'd2621440;
	localparam logic [CFG_W-1:0] STEP_RESET   = 31'd655;

	localparam logic [IDX_W-1:0] REG_GAIN_PROP     = 3'd0;
	localparam logic [IDX_W-1:0] REG_GAIN_INTEGRAL = 3'd1;
	localparam logic [IDX_W-1:0] REG_GAIN_DERIV    = 3'd2;
	localparam logic [IDX_W-1:0] REG_CUTOFF_RATE   = 3'd3;
	localparam logic [IDX_W-1:0] REG_STEP_TIME     = 3'd4;

	typedef enum logic [1:0] {
		MUL_IDLE,
		MUL_LO,
		MUL_HI,
		MUL_ACC
	} mul_state_t;

	typedef enum logic {
		DIV_IDLE,
		DIV_RUN
	} div_state_t;

	typedef enum logic [1:0] {
		SEQ_IDLE,
		SEQ_MUL_GO,
		SEQ_MUL_WAIT,
		SEQ_OUT
	} seq_state_t;

	typedef enum logic [3:0] {
		OP_WC2,
		OP_A1,
		OP_A1X0,
		OP_WC2X1,
		OP_WC2U,
		OP_STX0,
		OP_STD0,
		OP_KPE,
		OP_KII,
		OP_KDD
	} op_t;

endpackage

// ===== hdl/pid_filtered_derivative_top.sv =====
// PID controller with a second-order filtered derivative, all values signed Q16.16.
// Each accepted word (reference, measured) yields one drive word. The measurement
// rate comes from a bit-serial divider of 49 steps, and the ten Q16.16 products
// share one multiplier; the four products that do not need the rate overlap the
// divider, and the six that follow it start once the rate is there. The input is
// stalled while a sample is in work, but a new sample is taken while the previous
// drive word still waits at the output. Writing the cutoff rate clears both filter
// states; zero writes to the cutoff rate or the step time are ignored. Configuration
// must be written by the user only while the block is idle; the block itself does
// not enforce this.
module pid_filtered_derivative_top #(
	parameter int DATA_WIDTH = pfd_pkg::DATA_WIDTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wen,
	input  logic [pfd_pkg::IDX_W-1:0]         cfg_index,
	input  logic [pfd_pkg::WORD_W-1:0]        cfg_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic signed [pfd_pkg::WORD_W-1:0] reference,
	input  logic signed [pfd_pkg::WORD_W-1:0] measured,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic signed [pfd_pkg::WORD_W-1:0] drive
);

	localparam int WordW  = pfd_pkg::WORD_W;
	localparam int CfgW   = pfd_pkg::CFG_W;
	localparam int StateW = pfd_pkg::STATE_W;
	localparam int DiffW  = pfd_pkg::DIFF_W;
	localparam int OpndW  = pfd_pkg::OPND_W;
	localparam int SumW   = pfd_pkg::SUM_W;
	localparam int MagW   = pfd_pkg::MAG_W;
	localparam int SatW   = (DATA_WIDTH < SumW) ? DATA_WIDTH : SumW;

	localparam logic signed [SumW-1:0] ClampHi = SumW'(pfd_pkg::CLAMP_Q);
	localparam logic signed [SumW-1:0] ClampLo = -ClampHi;
	localparam logic signed [SumW-1:0] D0Hi    = $signed(SumW'(pfd_pkg::SAT_Q));
	localparam logic signed [SumW-1:0] D0Lo    = -D0Hi;
	localparam logic [SumW-1:0] DriveLo = {{(SumW-SatW+1){1'b1}}, {(SatW-1){1'b0}}};
	localparam logic [SumW-1:0] DriveHi = ~DriveLo;

	function automatic logic signed [StateW-1:0] clamp_st(input logic signed [SumW-1:0] v);
		logic signed [StateW-1:0] r;
		if (v > ClampHi) begin
			r = StateW'(ClampHi);
		end else if (v < ClampLo) begin
			r = StateW'(ClampLo);
		end else begin
			r = v[StateW-1:0];
		end
		return r;
	endfunction

	pfd_pkg::seq_state_t state_q, state_d;
	pfd_pkg::op_t        op_q;

	logic signed [WordW-1:0]  gain_prop_q, gain_integral_q, gain_deriv_q;
	logic [CfgW-1:0]          cutoff_q, step_q;
	logic signed [StateW-1:0] integ_q, prev_q, x0_q, x1_q;
	logic signed [DiffW-1:0]  err_q;
	logic                     diff_neg_q;
	logic signed [OpndW-1:0]  rate_q, wc2_q, a1_q;
	logic                     rate_ok_q;
	logic signed [SumW-1:0]   acc_q;
	logic [WordW-1:0]         drive_q;
	logic                     out_valid_q;

	logic                     accept, load_out, mul_start, div_start;
	logic signed [DiffW-1:0]  err_w, diff_w;
	logic [DiffW-1:0]         diff_mag;
	logic signed [SumW-1:0]   integ_sum;
	logic signed [OpndW-1:0]  d0_c, opa, opb;
	logic signed [OpndW-1:0]  mul_p;
	logic                     mul_done, div_done;
	logic [MagW-1:0]          div_q;
	logic signed [OpndW-1:0]  div_s;
	logic signed [SumW-1:0]   pw;
	logic [SumW-1:0]          drive_sat;
	logic [SumW-SatW:0]       drive_top;

	pfd_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.opnd_a (opa),
		.opnd_b (opb),
		.done   (mul_done),
		.prod   (mul_p)
	);

	pfd_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (diff_mag),
		.divisor  (step_q),
		.done     (div_done),
		.quotient (div_q)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pfd_pkg::SEQ_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		in_stall  = 1'b1;
		accept    = 1'b0;
		mul_start = 1'b0;
		div_start = 1'b0;
		load_out  = 1'b0;
		case (state_q)
			pfd_pkg::SEQ_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					accept    = 1'b1;
					div_start = 1'b1;
					state_d   = pfd_pkg::SEQ_MUL_GO;
				end
			end
			pfd_pkg::SEQ_MUL_GO: begin
				if (op_q != pfd_pkg::OP_WC2U || rate_ok_q) begin
					mul_start = 1'b1;
					state_d   = pfd_pkg::SEQ_MUL_WAIT;
				end
			end
			pfd_pkg::SEQ_MUL_WAIT: begin
				if (mul_done) begin
					state_d = (op_q == pfd_pkg::OP_KDD) ? pfd_pkg::SEQ_OUT : pfd_pkg::SEQ_MUL_GO;
				end
			end
			pfd_pkg::SEQ_OUT: begin
				if (!out_valid_q || !out_stall) begin
					load_out = 1'b1;
					state_d  = pfd_pkg::SEQ_IDLE;
				end
			end
			default: state_d = pfd_pkg::SEQ_IDLE;
		endcase
	end

	always_comb begin
		err_w     = DiffW'(reference) - DiffW'(measured);
		diff_w    = DiffW'(measured) - DiffW'(prev_q);
		diff_mag  = diff_w[DiffW-1] ? DiffW'(-diff_w) : DiffW'(diff_w);
		integ_sum = SumW'(integ_q) + SumW'(err_w);
		div_s     = $signed({1'b0, div_q});
		pw        = SumW'(mul_p);

		if (acc_q > D0Hi) begin
			d0_c = OpndW'(D0Hi);
		end else if (acc_q < D0Lo) begin
			d0_c = OpndW'(D0Lo);
		end else begin
			d0_c = acc_q[OpndW-1:0];
		end

		case (op_q)
			pfd_pkg::OP_WC2: begin
				opa = $signed(OpndW'(cutoff_q));
				opb = $signed(OpndW'(cutoff_q));
			end
			pfd_pkg::OP_A1: begin
				opa = OpndW'(pfd_pkg::SQRT2_Q);
				opb = $signed(OpndW'(cutoff_q));
			end
			pfd_pkg::OP_A1X0: begin
				opa = a1_q;
				opb = OpndW'(x0_q);
			end
			pfd_pkg::OP_WC2X1: begin
				opa = wc2_q;
				opb = OpndW'(x1_q);
			end
			pfd_pkg::OP_WC2U: begin
				opa = wc2_q;
				opb = rate_q;
			end
			pfd_pkg::OP_STX0: begin
				opa = $signed(OpndW'(step_q));
				opb = OpndW'(x0_q);
			end
			pfd_pkg::OP_STD0: begin
				opa = $signed(OpndW'(step_q));
				opb = d0_c;
			end
			pfd_pkg::OP_KPE: begin
				opa = OpndW'(gain_prop_q);
				opb = OpndW'(err_q);
			end
			pfd_pkg::OP_KII: begin
				opa = OpndW'(gain_integral_q);
				opb = OpndW'(integ_q);
			end
			pfd_pkg::OP_KDD: begin
				opa = OpndW'(gain_deriv_q);
				opb = OpndW'(x1_q);
			end
			default: begin
				opa = '0;
				opb = '0;
			end
		endcase

		drive_top = acc_q[SumW-1:SatW-1];
		if ((&drive_top) || !(|drive_top)) begin
			drive_sat = acc_q;
		end else begin
			drive_sat = acc_q[SumW-1] ? DriveLo : DriveHi;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_prop_q     <= '0;
			gain_integral_q <= '0;
			gain_deriv_q    <= '0;
			cutoff_q        <= pfd_pkg::CUTOFF_RESET;
			step_q          <= pfd_pkg::STEP_RESET;
			integ_q         <= '0;
			prev_q          <= '0;
			x0_q            <= '0;
			x1_q            <= '0;
			op_q            <= pfd_pkg::OP_WC2;
			rate_ok_q       <= 1'b0;
			out_valid_q     <= 1'b0;
		end else begin
			if (cfg_wen) begin
				case (cfg_index)
					pfd_pkg::REG_GAIN_PROP:     gain_prop_q     <= cfg_data;
					pfd_pkg::REG_GAIN_INTEGRAL: gain_integral_q <= cfg_data;
					pfd_pkg::REG_GAIN_DERIV:    gain_deriv_q    <= cfg_data;
					pfd_pkg::REG_CUTOFF_RATE: begin
						if (cfg_data[CfgW-1:0] != '0) begin
							cutoff_q <= cfg_data[CfgW-1:0];
							x0_q     <= '0;
							x1_q     <= '0;
						end
					end
					pfd_pkg::REG_STEP_TIME: begin
						if (cfg_data[CfgW-1:0] != '0) begin
							step_q <= cfg_data[CfgW-1:0];
						end
					end
					default: begin
					end
				endcase
			end

			if (accept) begin
				integ_q   <= clamp_st(integ_sum);
				prev_q    <= measured;
				op_q      <= pfd_pkg::OP_WC2;
				rate_ok_q <= 1'b0;
			end else if (div_done) begin
				rate_ok_q <= 1'b1;
			end

			if (state_q == pfd_pkg::SEQ_MUL_WAIT && mul_done) begin
				case (op_q)
					pfd_pkg::OP_STX0: x1_q <= clamp_st(SumW'(x1_q) + pw);
					pfd_pkg::OP_STD0: x0_q <= clamp_st(SumW'(x0_q) + pw);
					default: begin
					end
				endcase
				if (op_q != pfd_pkg::OP_KDD) begin
					op_q <= pfd_pkg::op_t'(op_q + 4'd1);
				end
			end

			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			err_q      <= err_w;
			diff_neg_q <= diff_w[DiffW-1];
		end
		if (div_done) begin
			rate_q <= diff_neg_q ? -div_s : div_s;
		end
		if (state_q == pfd_pkg::SEQ_MUL_WAIT && mul_done) begin
			case (op_q)
				pfd_pkg::OP_WC2:   wc2_q <= mul_p;
				pfd_pkg::OP_A1:    a1_q  <= mul_p;
				pfd_pkg::OP_A1X0:  acc_q <= -pw;
				pfd_pkg::OP_WC2X1: acc_q <= acc_q - pw;
				pfd_pkg::OP_WC2U:  acc_q <= acc_q + pw;
				pfd_pkg::OP_KPE:   acc_q <= pw;
				pfd_pkg::OP_KII:   acc_q <= acc_q + pw;
				pfd_pkg::OP_KDD:   acc_q <= acc_q + pw;
				default: begin
				end
			endcase
		end
		if (load_out) begin
			drive_q <= drive_sat[WordW-1:0];
		end
	end

	assign out_valid = out_valid_q;
	assign drive     = drive_q;

endmodule

// ===== hdl/pfd_mul.sv =====
module pfd_mul (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic signed [pfd_pkg::OPND_W-1:0]   opnd_a,
	input  logic signed [pfd_pkg::OPND_W-1:0]   opnd_b,
	output logic                                done,
	output logic signed [pfd_pkg::OPND_W-1:0]   prod
);

	localparam int OpndW  = pfd_pkg::OPND_W;
	localparam int ChunkW = pfd_pkg::CHUNK_W;
	localparam int ProdW  = OpndW + ChunkW;
	localparam int AccW   = 2 * OpndW;
	localparam int SatBit = pfd_pkg::MAG_W - 1 + pfd_pkg::FRAC_W;

	pfd_pkg::mul_state_t state_q, state_d;

	logic [OpndW-1:0] ma_q, mb_q;
	logic             neg_q;
	logic [ProdW-1:0] prod_q;
	logic [AccW-1:0]  acc_q;
	logic             done_q;

	logic                        over;
	logic [pfd_pkg::MAG_W-1:0]   mag_r;
	logic signed [OpndW-1:0]     mag_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pfd_pkg::MUL_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == pfd_pkg::MUL_ACC);
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			pfd_pkg::MUL_IDLE: begin
				if (start) begin
					state_d = pfd_pkg::MUL_LO;
				end
			end
			pfd_pkg::MUL_LO:  state_d = pfd_pkg::MUL_HI;
			pfd_pkg::MUL_HI:  state_d = pfd_pkg::MUL_ACC;
			pfd_pkg::MUL_ACC: state_d = pfd_pkg::MUL_IDLE;
			default:          state_d = pfd_pkg::MUL_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		case (state_q)
			pfd_pkg::MUL_IDLE: begin
				if (start) begin
					ma_q  <= opnd_a[OpndW-1] ? OpndW'(-opnd_a) : OpndW'(opnd_a);
					mb_q  <= opnd_b[OpndW-1] ? OpndW'(-opnd_b) : OpndW'(opnd_b);
					neg_q <= opnd_a[OpndW-1] ^ opnd_b[OpndW-1];
				end
			end
			pfd_pkg::MUL_LO: begin
				prod_q <= ProdW'(ma_q) * ProdW'(mb_q[ChunkW-1:0]);
			end
			pfd_pkg::MUL_HI: begin
				acc_q  <= AccW'(prod_q);
				prod_q <= ProdW'(ma_q) * ProdW'(mb_q[OpndW-1:ChunkW]);
			end
			pfd_pkg::MUL_ACC: begin
				acc_q <= acc_q + (AccW'(prod_q) << ChunkW);
			end
			default: begin
			end
		endcase
	end

	// Products at or above 2^62 saturate to 2^46 after the Q16.16 shift.
	always_comb begin
		over  = |acc_q[AccW-1:SatBit];
		mag_r = over ? pfd_pkg::SAT_Q : pfd_pkg::MAG_W'(acc_q[SatBit-1:pfd_pkg::FRAC_W]);
		mag_s = $signed({1'b0, mag_r});
	end

	assign prod = neg_q ? -mag_s : mag_s;
	assign done = done_q;

endmodule

// ===== hdl/pfd_div.sv =====
module pfd_div (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [pfd_pkg::DIFF_W-1:0]        dividend,
	input  logic [pfd_pkg::CFG_W-1:0]         divisor,
	output logic                              done,
	output logic [pfd_pkg::MAG_W-1:0]         quotient
);

	localparam int DvdW = pfd_pkg::DVD_W;
	localparam int DenW = pfd_pkg::CFG_W;
	localparam int CntW = $clog2(DvdW);

	pfd_pkg::div_state_t state_q, state_d;

	logic [CntW-1:0] cnt_q;
	logic [DvdW-1:0] dq_q;
	logic [DenW-1:0] rem_q;
	logic [DenW-1:0] den_q;
	logic            done_q;

	logic [DenW:0]   rem_sh;
	logic [DenW+1:0] trial;
	logic            fits;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pfd_pkg::DIV_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == pfd_pkg::DIV_RUN) && (cnt_q == '0);
			if (state_q == pfd_pkg::DIV_IDLE) begin
				cnt_q <= CntW'(DvdW - 1);
			end else begin
				cnt_q <= cnt_q - CntW'(1);
			end
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			pfd_pkg::DIV_IDLE: begin
				if (start) begin
					state_d = pfd_pkg::DIV_RUN;
				end
			end
			pfd_pkg::DIV_RUN: begin
				if (cnt_q == '0) begin
					state_d = pfd_pkg::DIV_IDLE;
				end
			end
			default: state_d = pfd_pkg::DIV_IDLE;
		endcase
	end

	always_comb begin
		rem_sh = {rem_q, dq_q[DvdW-1]};
		trial  = {1'b0, rem_sh} - {2'b0, den_q};
		fits   = !trial[DenW+1];
	end

	always_ff @(posedge clk) begin
		if (state_q == pfd_pkg::DIV_IDLE) begin
			if (start) begin
				dq_q  <= {dividend, {pfd_pkg::FRAC_W{1'b0}}};
				rem_q <= '0;
				den_q <= divisor;
			end
		end else begin
			rem_q <= fits ? trial[DenW-1:0] : rem_sh[DenW-1:0];
			dq_q  <= {dq_q[DvdW-2:0], fits};
		end
	end

	assign quotient = (dq_q > DvdW'(pfd_pkg::SAT_Q)) ? pfd_pkg::SAT_Q : dq_q[pfd_pkg::MAG_W-1:0];
	assign done     = done_q;

endmodule

// ===== tb/testbench.sv =====
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic signed [pfd_pkg::WORD_W-1:0] setpoint;
		logic signed [pfd_pkg::WORD_W-1:0] feedback;
	} sample_t;

	localparam logic signed [pfd_pkg::WORD_W-1:0] ONE_Q    = 32'sh0001_0000;
	localparam logic signed [pfd_pkg::WORD_W-1:0] WORD_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [pfd_pkg::WORD_W-1:0] WORD_MIN = 32'sh8000_0000;
	localparam longint SAT_LIM   = 64'sh4000_0000_0000;
	localparam logic [63:0] PROD_LIM = 64'h4000_0000_0000_0000;
	localparam longint DRIVE_HI  = 64'sh7FFF_FFFF;
	localparam longint DRIVE_LO  = -64'sh8000_0000;
	localparam int HOLD_CYCLES   = 400;
	localparam int RANDOM_PHASES = 9;
	localparam int PHASE_ITEMS   = 200;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wen = 1'b0;
	logic [pfd_pkg::IDX_W-1:0] cfg_index = '0;
	logic [pfd_pkg::WORD_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [pfd_pkg::WORD_W-1:0] reference = '0;
	logic signed [pfd_pkg::WORD_W-1:0] measured = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [pfd_pkg::WORD_W-1:0] drive;

	pid_filtered_derivative_top i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wen(cfg_wen),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.reference(reference),
		.measured(measured),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.drive(drive)
	);

	longint gain_p_q;
	longint gain_i_q;
	longint gain_d_q;
	longint cutoff_q;
	longint step_q;
	longint err_sum;
	longint prev_fb;
	longint flt_rate;
	longint flt_out;

	sample_t pending_samples[$];
	logic signed [pfd_pkg::WORD_W-1:0] drive_expected[$];
	int issued = 0;
	int received = 0;
	int error_count = 0;
	int send_wait = 0;
	int recv_wait = 0;
	int send_gap_max = 6;
	int recv_gap_max = 6;
	int hold_left = 0;
	logic hold_start = 1'b0;
	logic signed [pfd_pkg::WORD_W-1:0] walk_sp = '0;
	logic signed [pfd_pkg::WORD_W-1:0] walk_fb = '0;
	sample_t cur_sample;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic longint q_mul(input longint a, input longint b);
		logic [63:0] ma, mb, r;
		ma = (a < 0) ? -a : a;
		mb = (b < 0) ? -b : b;
		if (ma != 0 && mb > PROD_LIM / ma)
			r = SAT_LIM;
		else
			r = (ma * mb) >> 16;
		if (r > SAT_LIM)
			r = SAT_LIM;
		return ((a < 0) != (b < 0)) ? -$signed(r) : $signed(r);
	endfunction

	function automatic longint q_div(input longint a, input longint d);
		logic [63:0] ma, md, r;
		ma = (a < 0) ? -a : a;
		md = (d < 0) ? -d : d;
		if (md == 0)
			return 0;
		r = (ma << 16) / md;
		if (r > SAT_LIM)
			r = SAT_LIM;
		return ((a < 0) != (d < 0)) ? -$signed(r) : $signed(r);
	endfunction

	function automatic longint clamp(input longint v, input longint lim);
		if (v > lim)
			return lim;
		if (v < -lim)
			return -lim;
		return v;
	endfunction

	function automatic logic signed [pfd_pkg::WORD_W-1:0] advance_controller(
		input logic signed [pfd_pkg::WORD_W-1:0] sp,
		input logic signed [pfd_pkg::WORD_W-1:0] fb
	);
		longint fb_l, err, rate, wc2, a1, x0, x1, d0, acc;
		fb_l = longint'(fb);
		err = longint'(sp) - fb_l;
		rate = q_div(fb_l - prev_fb, step_q);
		wc2 = q_mul(cutoff_q, cutoff_q);
		a1 = q_mul(longint'(pfd_pkg::SQRT2_Q), cutoff_q);
		x0 = flt_rate;
		x1 = flt_out;
		d0 = -q_mul(a1, x0) - q_mul(wc2, x1) + q_mul(wc2, rate);
		d0 = clamp(d0, SAT_LIM);
		flt_rate = clamp(x0 + q_mul(step_q, d0), longint'(pfd_pkg::CLAMP_Q));
		flt_out = clamp(x1 + q_mul(step_q, x0), longint'(pfd_pkg::CLAMP_Q));
		prev_fb = fb_l;
		err_sum = clamp(err_sum + err, longint'(pfd_pkg::CLAMP_Q));
		acc = q_mul(gain_p_q, err) + q_mul(gain_i_q, err_sum) + q_mul(gain_d_q, flt_out);
		if (acc > DRIVE_HI)
			acc = DRIVE_HI;
		else if (acc < DRIVE_LO)
			acc = DRIVE_LO;
		return acc[pfd_pkg::WORD_W-1:0];
	endfunction

	task automatic write_reg(input logic [pfd_pkg::IDX_W-1:0] idx,
		input logic [pfd_pkg::WORD_W-1:0] data);
		@(posedge clk);
		cfg_wen <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		case (idx)
			pfd_pkg::REG_GAIN_PROP: gain_p_q = longint'($signed(data));
			pfd_pkg::REG_GAIN_INTEGRAL: gain_i_q = longint'($signed(data));
			pfd_pkg::REG_GAIN_DERIV: gain_d_q = longint'($signed(data));
			pfd_pkg::REG_CUTOFF_RATE: begin
				if (data[pfd_pkg::CFG_W-1:0] != 0) begin
					cutoff_q = data[pfd_pkg::CFG_W-1:0];
					flt_rate = 0;
					flt_out = 0;
				end
			end
			pfd_pkg::REG_STEP_TIME: begin
				if (data[pfd_pkg::CFG_W-1:0] != 0)
					step_q = data[pfd_pkg::CFG_W-1:0];
			end
			default: ;
		endcase
		@(posedge clk);
		cfg_wen <= 1'b0;
	endtask

	task automatic push_sample(input logic [pfd_pkg::WORD_W-1:0] sp,
		input logic [pfd_pkg::WORD_W-1:0] fb);
		sample_t s;
		s.setpoint = sp;
		s.feedback = fb;
		pending_samples.push_back(s);
	endtask

	task automatic wait_drained();
		do
			@(posedge clk);
		while (pending_samples.size() != 0 || received != issued);
	endtask

	task automatic queue_random(input int count);
		for (int n = 0; n < count; n++) begin
			if ($urandom_range(0, 9) < 7) begin
				if ($urandom_range(0, 15) == 0)
					walk_sp = $urandom_range(0, 32'h50_0000) - 32'h28_0000;
				if ($urandom_range(0, 7) != 0)
					walk_fb = walk_fb + ($urandom_range(0, 32'h3_FFFF) - 32'h2_0000);
				if (walk_fb > 32'sh32_0000 || walk_fb < -32'sh32_0000)
					walk_fb = walk_sp;
				push_sample(walk_sp, walk_fb);
			end else begin
				push_sample($urandom, $urandom);
			end
		end
	endtask

	task automatic load_settings(input int k);
		logic [pfd_pkg::WORD_W-1:0] g[3];
		logic [pfd_pkg::WORD_W-1:0] wc, dt;
		case (k)
			0: begin
				g = '{WORD_MAX, WORD_MAX, WORD_MAX};
				wc = 32'h7FFF_FFFF;
				dt = 32'd1;
			end
			1: begin
				g = '{WORD_MIN, WORD_MIN, WORD_MIN};
				wc = 32'd1;
				dt = 32'h7FFF_FFFF;
			end
			default: begin
				for (int j = 0; j < 3; j++)
					g[j] = $urandom_range(0, 1) ? $urandom_range(0, 32'h7_FFFF) - 32'h4_0000
						: $urandom;
				wc = ($urandom_range(0, 3) != 0) ? $urandom_range(32'h1_0000, 32'hC8_0000)
					: $urandom;
				dt = ($urandom_range(0, 3) != 0) ? $urandom_range(1, 32'h1999) : $urandom;
			end
		endcase
		write_reg(pfd_pkg::REG_GAIN_PROP, g[0]);
		write_reg(pfd_pkg::REG_GAIN_INTEGRAL, g[1]);
		write_reg(pfd_pkg::REG_GAIN_DERIV, g[2]);
		write_reg(pfd_pkg::REG_CUTOFF_RATE, wc);
		write_reg(pfd_pkg::REG_STEP_TIME, dt);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			send_wait = 0;
		end else begin
			if (in_valid && !in_stall)
				drive_expected.push_back(advance_controller(reference, measured));
			if (!in_valid || !in_stall) begin
				if (send_wait != 0) begin
					send_wait--;
					in_valid <= 1'b0;
				end else if (pending_samples.size() != 0) begin
					cur_sample = pending_samples.pop_front();
					reference <= cur_sample.setpoint;
					measured <= cur_sample.feedback;
					in_valid <= 1'b1;
					issued++;
					send_wait = $urandom_range(0, send_gap_max);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			hold_left <= 0;
		else if (hold_start)
			hold_left <= HOLD_CYCLES;
		else if (hold_left != 0)
			hold_left <= hold_left - 1;
	end

	always @(posedge clk or negedge arst_n) begin
		logic signed [pfd_pkg::WORD_W-1:0] want;
		if (!arst_n) begin
			out_stall <= 1'b0;
			recv_wait = 0;
		end else begin
			if (out_valid && !out_stall) begin
				received++;
				if (drive_expected.size() == 0) begin
					error_count++;
					if (error_count <= 10)
						$display("unexpected drive word %0d", drive);
				end else begin
					want = drive_expected.pop_front();
					if (drive !== want) begin
						error_count++;
						if (error_count <= 10)
							$display("drive mismatch: expected %0d, got %0d", want, drive);
					end
				end
				recv_wait = $urandom_range(0, recv_gap_max);
			end else if (recv_wait != 0) begin
				recv_wait--;
			end
			out_stall <= (hold_left != 0) || (recv_wait != 0);
		end
	end

	initial begin
		#4_000_000;
		$display("testbench: errors");
		$finish;
	end

	initial begin
		gain_p_q = 0;
		gain_i_q = 0;
		gain_d_q = 0;
		cutoff_q = pfd_pkg::CUTOFF_RESET;
		step_q = pfd_pkg::STEP_RESET;
		err_sum = 0;
		prev_fb = 0;
		flt_rate = 0;
		flt_out = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// With the reset gains every drive word is zero.
		push_sample(ONE_Q, -ONE_Q);
		wait_drained();

		write_reg(pfd_pkg::REG_GAIN_PROP, ONE_Q);
		write_reg(pfd_pkg::REG_GAIN_INTEGRAL, 32'h0000_4000);
		write_reg(pfd_pkg::REG_GAIN_DERIV, 32'h0000_0CCC);
		write_reg(pfd_pkg::REG_CUTOFF_RATE, 32'h0028_0000);
		write_reg(pfd_pkg::REG_STEP_TIME, 32'd655);
		push_sample(ONE_Q, ONE_Q >>> 1);
		push_sample(ONE_Q, ONE_Q >>> 1);
		push_sample(WORD_MAX, WORD_MIN);
		push_sample(WORD_MIN, WORD_MAX);
		push_sample(WORD_MAX, WORD_MAX);
		push_sample(WORD_MIN, WORD_MIN);
		push_sample('0, '0);
		push_sample(32'sh0064_0000, '0);
		push_sample(32'sh0064_0000, '0);
		push_sample(WORD_MIN, '0);
		wait_drained();

		write_reg(pfd_pkg::REG_GAIN_PROP, WORD_MAX);
		write_reg(pfd_pkg::REG_GAIN_INTEGRAL, WORD_MAX);
		write_reg(pfd_pkg::REG_GAIN_DERIV, WORD_MAX);
		push_sample(WORD_MAX, WORD_MIN);
		wait_drained();
		write_reg(pfd_pkg::REG_GAIN_PROP, WORD_MIN);
		write_reg(pfd_pkg::REG_GAIN_INTEGRAL, WORD_MIN);
		write_reg(pfd_pkg::REG_GAIN_DERIV, WORD_MIN);
		push_sample(WORD_MAX, WORD_MIN);
		wait_drained();

		// Zero writes to the cutoff or the step time, and unmapped indexes, change nothing.
		write_reg(pfd_pkg::REG_GAIN_PROP, ONE_Q);
		write_reg(pfd_pkg::REG_GAIN_INTEGRAL, ONE_Q);
		write_reg(pfd_pkg::REG_GAIN_DERIV, ONE_Q);
		write_reg(pfd_pkg::REG_CUTOFF_RATE, 32'h8000_0000);
		write_reg(pfd_pkg::REG_STEP_TIME, '0);
		for (int u = pfd_pkg::REG_STEP_TIME + 1; u < (1 << pfd_pkg::IDX_W); u++)
			write_reg(u[pfd_pkg::IDX_W-1:0], $urandom);
		push_sample(ONE_Q, ONE_Q <<< 1);
		push_sample(ONE_Q, ONE_Q <<< 2);
		wait_drained();
		write_reg(pfd_pkg::REG_CUTOFF_RATE, 32'h0064_0000);
		push_sample(ONE_Q, ONE_Q <<< 2);
		push_sample(-ONE_Q, ONE_Q);
		wait_drained();

		for (int k = 0; k < RANDOM_PHASES; k++) begin
			load_settings(k);
			send_gap_max = (k % 3 == 2) ? 0 : 6;
			recv_gap_max = (k % 4 == 3) ? 0 : 6;
			if (k == 4) begin
				send_gap_max = 0;
				recv_gap_max = 0;
			end
			queue_random(PHASE_ITEMS);
			if (k == 2) begin
				@(posedge clk);
				hold_start <= 1'b1;
				@(posedge clk);
				hold_start <= 1'b0;
			end
			wait_drained();
		end

		repeat (100) @(posedge clk);
		if (error_count == 0 && drive_expected.size() == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

endmodule

// ===== files.f =====
hdl/pfd_pkg.sv
hdl/pfd_mul.sv
hdl/pfd_div.sv
hdl/pid_filtered_derivative_top.sv
tb/testbench.sv
